FILE: rtl/arm_dump_and_gripper_sequencer_core_macros.svh
// Assertion macros for the checker file of the arm sequencer core.
`ifndef ARM_DUMP_AND_GRIPPER_SEQUENCER_CORE_MACROS_SVH
`define ARM_DUMP_AND_GRIPPER_SEQUENCER_CORE_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ADGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every rising clock edge, including during reset.
`define ADGS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/adgs_pkg.sv
// Shared types and constants of the arm dump and gripper sequencer.
`default_nettype none

package adgs_pkg;

    // Default parameter values.
    localparam int TIMER_BITS_DEF = 13;
    localparam int FORCE_BITS_DEF = 24;

    // Field widths.
    localparam int ANGLE_W    = 8;
    localparam int GRIP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Input item modes.
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_TOGGLE = 3'd1;
    localparam logic [2:0] MODE_OPEN   = 3'd2;
    localparam logic [2:0] MODE_DUMP   = 3'd3;
    localparam logic [2:0] MODE_SET    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_FORCE_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUMP_SHOULDER_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUMP_ELBOW_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUMP_WRIST_TILT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUMP_PAUSE_MS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIMEOUT_MS     = 3'd6;

    // Angle limits and home positions.
    localparam logic [ANGLE_W-1:0] TWIST_HOME      = 8'd90;
    localparam logic [ANGLE_W-1:0] SHOULDER_HOME   = 8'd75;
    localparam logic [ANGLE_W-1:0] ELBOW_HOME      = 8'd60;
    localparam logic [ANGLE_W-1:0] SHOULDER_MIN    = 8'd60;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX       = 8'd180;
    localparam logic [ANGLE_W-1:0] ELBOW_OFFSET    = 8'd3;
    localparam logic [ANGLE_W-1:0] WRIST_OFFSET    = 8'd12;
    localparam logic [ANGLE_W-1:0] WRIST_HOME_PHYS = 8'd15;
    localparam logic [GRIP_W-1:0]  GRIP_MIN        = 7'd45;
    localparam logic [GRIP_W-1:0]  GRIP_MAX        = 7'd120;

    // Timing constants in ticks.
    localparam int GRIP_CLOSE_MS = 40;
    localparam int GRIP_OPEN_MS  = 20;
    localparam int FORCE_READ_MS = 50;

    // Reset values of the configuration registers.
    localparam logic [22:0] GRIP_FORCE_LIMIT_RST     = 23'd1000;
    localparam logic [7:0]  DUMP_SHOULDER_TARGET_RST = 8'd120;
    localparam logic [7:0]  DUMP_ELBOW_TARGET_RST    = 8'd15;
    localparam logic [7:0]  DUMP_WRIST_TILT_RST      = 8'd120;
    localparam logic [9:0]  STEP_INTERVAL_MS_RST     = 10'd50;
    localparam logic [12:0] DUMP_PAUSE_MS_RST        = 13'd1000;
    localparam logic [12:0] CLOSE_TIMEOUT_MS_RST     = 13'd5000;

    // One input item.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [23:0] force_sample;
        logic [1:0]         joint_select;
        logic [7:0]         joint_angle;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] twist_cmd;
        logic [7:0] shoulder_cmd;
        logic [7:0] elbow_cmd;
        logic [7:0] wrist_cmd;
        logic [6:0] gripper_cmd;
        logic [2:0] dump_phase;
        logic [1:0] gripper_phase;
    } out_item_t;

    // Configuration register contents.
    typedef struct packed {
        logic [22:0] grip_force_limit;
        logic [7:0]  dump_shoulder_target;
        logic [7:0]  dump_elbow_target;
        logic [7:0]  dump_wrist_tilt;
        logic [9:0]  step_interval_ms;
        logic [12:0] dump_pause_ms;
        logic [12:0] close_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/adgs_cfg.sv
// Configuration register file of the arm sequencer.
`default_nettype none

module adgs_cfg
    import adgs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write transfer; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_GRIP_FORCE_LIMIT:     cfg_next.grip_force_limit     = cfg_data[22:0];
                REG_DUMP_SHOULDER_TARGET: cfg_next.dump_shoulder_target = cfg_data[7:0];
                REG_DUMP_ELBOW_TARGET:    cfg_next.dump_elbow_target    = cfg_data[7:0];
                REG_DUMP_WRIST_TILT:      cfg_next.dump_wrist_tilt      = cfg_data[7:0];
                REG_STEP_INTERVAL_MS:     cfg_next.step_interval_ms     = cfg_data[9:0];
                REG_DUMP_PAUSE_MS:        cfg_next.dump_pause_ms        = cfg_data[12:0];
                REG_CLOSE_TIMEOUT_MS:     cfg_next.close_timeout_ms     = cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Register storage with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grip_force_limit     <= GRIP_FORCE_LIMIT_RST;
            cfg_reg.dump_shoulder_target <= DUMP_SHOULDER_TARGET_RST;
            cfg_reg.dump_elbow_target    <= DUMP_ELBOW_TARGET_RST;
            cfg_reg.dump_wrist_tilt      <= DUMP_WRIST_TILT_RST;
            cfg_reg.step_interval_ms     <= STEP_INTERVAL_MS_RST;
            cfg_reg.dump_pause_ms        <= DUMP_PAUSE_MS_RST;
            cfg_reg.close_timeout_ms     <= CLOSE_TIMEOUT_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/adgs_seq.sv
// Joint, dump and gripper state with the next-state logic for one item.
`default_nettype none

module adgs_seq
    import adgs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int FORCE_BITS = FORCE_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    localparam int CMP_BITS = (TIMER_BITS > 13) ? TIMER_BITS : 13;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    localparam logic [1:0] JOINT_TWIST    = 2'd0;
    localparam logic [1:0] JOINT_SHOULDER = 2'd1;
    localparam logic [1:0] JOINT_ELBOW    = 2'd2;

    typedef enum logic [2:0] {
        TIP_IDLE, TIP_TWIST_OUT, TIP_ARM_OUT, TIP_WAIT_PRE,
        TIP_TILT, TIP_WAIT_POST, TIP_ARM_BACK, TIP_TWIST_BACK
    } dump_phase_t;

    typedef enum logic [1:0] {
        GRIP_IDLE, GRIP_CLOSING, GRIP_HOLDING, GRIP_OPENING
    } grip_phase_t;

    dump_phase_t dump_reg, dump_next;
    grip_phase_t grip_reg, grip_next;
    logic [ANGLE_W-1:0] twist_reg, twist_next;
    logic [ANGLE_W-1:0] shoulder_reg, shoulder_next;
    logic [ANGLE_W-1:0] elbow_reg, elbow_next;
    logic [ANGLE_W-1:0] wrist_reg, wrist_next;
    logic [GRIP_W-1:0]  gripper_reg, gripper_next;
    logic [ANGLE_W-1:0] saved_twist_reg, saved_twist_next;
    logic [ANGLE_W-1:0] saved_shoulder_reg, saved_shoulder_next;
    logic [ANGLE_W-1:0] saved_elbow_reg, saved_elbow_next;
    logic [TIMER_BITS-1:0] dump_step_reg, dump_step_next;
    logic [TIMER_BITS-1:0] dump_pause_reg, dump_pause_next;
    logic [TIMER_BITS-1:0] grip_step_reg, grip_step_next;
    logic [TIMER_BITS-1:0] close_reg, close_next;
    logic [TIMER_BITS-1:0] force_tmr_reg, force_tmr_next;
    logic signed [FORCE_BITS-1:0] force_reg, force_next;

    logic [ANGLE_W-1:0] level;
    logic               stepping;
    logic [ANGLE_W-1:0] tgt_shoulder;
    logic [ANGLE_W-1:0] tgt_elbow;

    // Saturating timer increment.
    function automatic logic [TIMER_BITS-1:0] tinc(input logic [TIMER_BITS-1:0] t);
        return (t == TMAX) ? t : t + 1'b1;
    endfunction

    // Timer compare against a limit that may be wider than the timer.
    function automatic logic t_gt(input logic [TIMER_BITS-1:0] t,
                                  input logic [CMP_BITS-1:0]   lim);
        return CMP_BITS'(t) > lim;
    endfunction

    // One degree toward the target.
    function automatic logic [ANGLE_W-1:0] step_toward(input logic [ANGLE_W-1:0] cur,
                                                       input logic [ANGLE_W-1:0] tgt);
        if (cur < tgt) begin
            return cur + 1'b1;
        end else if (cur > tgt) begin
            return cur - 1'b1;
        end
        return cur;
    endfunction

    // Wrist physical angle from a logical angle.
    function automatic logic [ANGLE_W-1:0] wrist_phys(input logic [ANGLE_W-1:0] logical);
        logic [ANGLE_W:0] sum;
        sum = {1'b0, logical} + {1'b0, WRIST_OFFSET};
        return (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
    endfunction

    // Leveling angle: shoulder + elbow + 3 - 135, clamped to 0..180.
    function automatic logic [ANGLE_W-1:0] level_of(input logic [ANGLE_W-1:0] sh,
                                                    input logic [ANGLE_W-1:0] el);
        logic [ANGLE_W+1:0] sum;
        logic [ANGLE_W+1:0] base;
        logic [ANGLE_W+1:0] diff;
        sum  = {2'b0, sh} + {2'b0, el} + {2'b0, ELBOW_OFFSET};
        base = {2'b0, SHOULDER_HOME} + {2'b0, ELBOW_HOME};
        diff = sum - base;
        if (sum < base) begin
            return '0;
        end else if (diff > {2'b0, ANGLE_MAX}) begin
            return ANGLE_MAX;
        end
        return diff[ANGLE_W-1:0];
    endfunction

    // Angle clamp to min..180.
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a,
                                                       input logic [ANGLE_W-1:0] lo);
        if (a < lo) begin
            return lo;
        end else if (a > ANGLE_MAX) begin
            return ANGLE_MAX;
        end
        return a;
    endfunction

    assign level = level_of(shoulder_reg, elbow_reg);

    // Next state for the item in the input register.
    always_comb begin
        dump_next           = dump_reg;
        grip_next           = grip_reg;
        twist_next          = twist_reg;
        shoulder_next       = shoulder_reg;
        elbow_next          = elbow_reg;
        wrist_next          = wrist_reg;
        gripper_next        = gripper_reg;
        saved_twist_next    = saved_twist_reg;
        saved_shoulder_next = saved_shoulder_reg;
        saved_elbow_next    = saved_elbow_reg;
        dump_step_next      = dump_step_reg;
        dump_pause_next     = dump_pause_reg;
        grip_step_next      = grip_step_reg;
        close_next          = close_reg;
        force_tmr_next      = force_tmr_reg;
        force_next          = force_reg;
        stepping            = 1'b0;
        tgt_shoulder        = (dump_reg == TIP_ARM_OUT) ? cfg.dump_shoulder_target
                                                        : saved_shoulder_reg;
        tgt_elbow           = (dump_reg == TIP_ARM_OUT) ? cfg.dump_elbow_target
                                                        : saved_elbow_reg;

        case (item.mode)
            MODE_TICK: begin
                dump_step_next  = tinc(dump_step_reg);
                dump_pause_next = tinc(dump_pause_reg);
                grip_step_next  = tinc(grip_step_reg);
                force_tmr_next  = tinc(force_tmr_reg);

                // Keep the wrist level while no dump runs.
                if (dump_reg == TIP_IDLE) begin
                    wrist_next = wrist_phys(level);
                end

                // Dump sequence.
                stepping = t_gt(dump_step_next, CMP_BITS'(cfg.step_interval_ms));
                case (dump_reg)
                    TIP_TWIST_OUT: begin
                        if (stepping) begin
                            if (twist_reg != TWIST_HOME) begin
                                twist_next = step_toward(twist_reg, TWIST_HOME);
                            end else begin
                                dump_next = TIP_ARM_OUT;
                            end
                            dump_step_next = '0;
                        end
                    end
                    TIP_ARM_OUT, TIP_ARM_BACK: begin
                        if (stepping) begin
                            if (shoulder_reg == tgt_shoulder && elbow_reg == tgt_elbow) begin
                                if (dump_reg == TIP_ARM_OUT) begin
                                    dump_next       = TIP_WAIT_PRE;
                                    dump_pause_next = '0;
                                end else begin
                                    dump_next = TIP_TWIST_BACK;
                                end
                            end
                            shoulder_next  = step_toward(shoulder_reg, tgt_shoulder);
                            elbow_next     = step_toward(elbow_reg, tgt_elbow);
                            dump_step_next = '0;
                        end
                    end
                    TIP_WAIT_PRE: begin
                        if (t_gt(dump_pause_next, CMP_BITS'(cfg.dump_pause_ms))) begin
                            dump_next = TIP_TILT;
                        end
                    end
                    TIP_TILT: begin
                        wrist_next      = wrist_phys(cfg.dump_wrist_tilt);
                        dump_pause_next = '0;
                        dump_next       = TIP_WAIT_POST;
                    end
                    TIP_WAIT_POST: begin
                        if (t_gt(dump_pause_next, CMP_BITS'(cfg.dump_pause_ms))) begin
                            wrist_next = wrist_phys(level);
                            dump_next  = TIP_ARM_BACK;
                        end
                    end
                    TIP_TWIST_BACK: begin
                        if (stepping) begin
                            if (twist_reg != saved_twist_reg) begin
                                twist_next = step_toward(twist_reg, saved_twist_reg);
                            end else begin
                                dump_next = TIP_IDLE;
                            end
                            dump_step_next = '0;
                        end
                    end
                    default: ;
                endcase

                // Load cell sampling, ahead of the gripper.
                if (force_tmr_next > TIMER_BITS'(FORCE_READ_MS)) begin
                    force_next     = FORCE_BITS'(item.force_sample);
                    force_tmr_next = '0;
                end

                // Gripper close and open.
                case (grip_reg)
                    GRIP_CLOSING: begin
                        if (force_next > $signed({1'b0, cfg.grip_force_limit})) begin
                            grip_next = GRIP_HOLDING;
                        end else if (t_gt(close_reg, CMP_BITS'(cfg.close_timeout_ms))) begin
                            grip_next = GRIP_OPENING;
                        end else begin
                            if (grip_step_next > TIMER_BITS'(GRIP_CLOSE_MS)) begin
                                gripper_next   = (gripper_reg >= GRIP_MAX) ? GRIP_MAX
                                                                           : gripper_reg + 1'b1;
                                grip_step_next = '0;
                            end
                            close_next = tinc(close_reg);
                        end
                    end
                    GRIP_OPENING: begin
                        if (grip_step_next > TIMER_BITS'(GRIP_OPEN_MS)) begin
                            gripper_next   = (gripper_reg <= GRIP_MIN + 7'd2) ? GRIP_MIN
                                                                              : gripper_reg - 7'd2;
                            grip_step_next = '0;
                        end
                        if (gripper_next <= GRIP_MIN) begin
                            grip_next = GRIP_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TOGGLE: begin
                if (grip_reg == GRIP_IDLE) begin
                    grip_next  = GRIP_CLOSING;
                    close_next = '0;
                end else begin
                    grip_next = GRIP_OPENING;
                end
            end
            MODE_OPEN: begin
                grip_next = GRIP_OPENING;
            end
            MODE_DUMP: begin
                if (grip_reg == GRIP_HOLDING && dump_reg == TIP_IDLE) begin
                    saved_twist_next    = twist_reg;
                    saved_shoulder_next = shoulder_reg;
                    saved_elbow_next    = elbow_reg;
                    dump_next           = TIP_TWIST_OUT;
                end
            end
            MODE_SET: begin
                case (item.joint_select)
                    JOINT_TWIST:    twist_next    = clamp_angle(item.joint_angle, '0);
                    JOINT_SHOULDER: shoulder_next = clamp_angle(item.joint_angle, SHOULDER_MIN);
                    JOINT_ELBOW:    elbow_next    = clamp_angle(item.joint_angle, '0);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Result fields from the updated state.
    always_comb begin
        logic [ANGLE_W:0] elbow_sum;
        elbow_sum            = {1'b0, elbow_next} + {1'b0, ELBOW_OFFSET};
        result.twist_cmd     = clamp_angle(twist_next, '0);
        result.shoulder_cmd  = clamp_angle(shoulder_next, SHOULDER_MIN);
        result.elbow_cmd     = (elbow_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX
                                                               : elbow_sum[ANGLE_W-1:0];
        result.wrist_cmd     = wrist_next;
        result.gripper_cmd   = gripper_next;
        result.dump_phase    = dump_next;
        result.gripper_phase = grip_next;
    end

    // State and timers, updated when the item moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dump_reg       <= TIP_IDLE;
            grip_reg       <= GRIP_IDLE;
            twist_reg      <= TWIST_HOME;
            shoulder_reg   <= SHOULDER_HOME;
            elbow_reg      <= ELBOW_HOME;
            wrist_reg      <= WRIST_HOME_PHYS;
            gripper_reg    <= GRIP_MIN;
            dump_step_reg  <= '0;
            dump_pause_reg <= '0;
            grip_step_reg  <= '0;
            close_reg      <= '0;
            force_tmr_reg  <= '0;
            force_reg      <= '0;
        end else if (advance) begin
            dump_reg       <= dump_next;
            grip_reg       <= grip_next;
            twist_reg      <= twist_next;
            shoulder_reg   <= shoulder_next;
            elbow_reg      <= elbow_next;
            wrist_reg      <= wrist_next;
            gripper_reg    <= gripper_next;
            dump_step_reg  <= dump_step_next;
            dump_pause_reg <= dump_pause_next;
            grip_step_reg  <= grip_step_next;
            close_reg      <= close_next;
            force_tmr_reg  <= force_tmr_next;
            force_reg      <= force_next;
        end
    end

    // Angles saved at dump start; written before they are read, so no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            saved_twist_reg    <= saved_twist_next;
            saved_shoulder_reg <= saved_shoulder_next;
            saved_elbow_reg    <= saved_elbow_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/arm_dump_and_gripper_sequencer_core.sv
// Top level of the arm dump and gripper sequencer.
`default_nettype none

// Servo sequencer for a four-joint arm with a gripper. Every input transfer is a
// one-millisecond tick or a command and yields exactly one result transfer with
// the clamped servo angles and the dump and gripper phases. The block takes one
// item per clock cycle while the result side does not stall; an item passes
// through the input register, then through the next-state logic into the
// result register, and a stalled result only stops input once the input
// register is also full. The configuration port takes a write in every cycle;
// registers are meant to be written only while no item is in flight.
module arm_dump_and_gripper_sequencer_core
    import adgs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int FORCE_BITS = FORCE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    // The held item moves on when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    adgs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adgs_seq #(
        .TIMER_BITS (TIMER_BITS),
        .FORCE_BITS (FORCE_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register valid and result register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/adgs_checker.sv
// Port-level checker for the arm sequencer core and its bind.
`default_nettype none

`include "arm_dump_and_gripper_sequencer_core_macros.svh"

module adgs_checker
    import adgs_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A stalled result transfer keeps its contents.
    `ADGS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // Reset empties the result register.
    `ADGS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // Gripper angle stays within its travel.
    `ADGS_ASSERT(a_grip_range, m_valid |-> m_data.gripper_cmd >= GRIP_MIN && m_data.gripper_cmd <= GRIP_MAX, "gripper angle out of range")

    // Shoulder command stays within its clamp.
    `ADGS_ASSERT(a_shoulder_range, m_valid |-> m_data.shoulder_cmd >= SHOULDER_MIN && m_data.shoulder_cmd <= ANGLE_MAX, "shoulder angle out of range")

    // An input transfer into an empty block shows a result after the input and result registers.
    `ADGS_ASSERT(a_latency, s_valid && s_ready && !m_valid |=> 1'b1 ##1 m_valid, "result missing after input transfer")

endmodule

bind arm_dump_and_gripper_sequencer_core adgs_checker u_adgs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: tb/tb_arm_dump_and_gripper_sequencer_core.sv
// Self-checking testbench for the arm dump and gripper sequencer core.
`timescale 1ns / 100ps

module tb_arm_dump_and_gripper_sequencer_core;
    import adgs_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int MAX_CYCLES    = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DUMP_TICK_CAP = 300;

    // Dump sequence phases.
    localparam logic [2:0] TIP_IDLE       = 3'd0;
    localparam logic [2:0] TIP_TWIST_OUT  = 3'd1;
    localparam logic [2:0] TIP_ARM_OUT    = 3'd2;
    localparam logic [2:0] TIP_WAIT_PRE   = 3'd3;
    localparam logic [2:0] TIP_TILT       = 3'd4;
    localparam logic [2:0] TIP_WAIT_POST  = 3'd5;
    localparam logic [2:0] TIP_ARM_BACK   = 3'd6;
    localparam logic [2:0] TIP_TWIST_BACK = 3'd7;

    // Gripper phases.
    localparam logic [1:0] JAW_IDLE    = 2'd0;
    localparam logic [1:0] JAW_CLOSING = 2'd1;
    localparam logic [1:0] JAW_HOLDING = 2'd2;
    localparam logic [1:0] JAW_OPENING = 2'd3;

    // Joint selectors of a set command.
    localparam logic [1:0] SEL_TWIST    = 2'd0;
    localparam logic [1:0] SEL_SHOULDER = 2'd1;
    localparam logic [1:0] SEL_ELBOW    = 2'd2;
    localparam logic [1:0] SEL_NONE     = 2'd3;

    // Modes that the block ignores.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic [23:0] FORCE_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] FORCE_NEG_MAX = 24'h800000;
    localparam int          FORCE_TOP     = 8388607;
    localparam logic [22:0] LIMIT_TOP     = 23'h7FFFFF;

    typedef logic [TIMER_BITS_DEF-1:0] timer_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    arm_dump_and_gripper_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Items waiting to be sent and servo commands still owed by the block.
    in_item_t  items_to_send[$];
    out_item_t servo_cmds_due[$];

    int errors      = 0;
    int phase_items = 0;
    int cycle_count = 0;
    int in_wait     = 0;
    int out_wait    = 0;
    bit idle_in     = 1'b1;
    bit idle_out    = 1'b1;

    // Shadow of the block: configuration, phases, angles and timers.
    cfg_t             cfg_m;
    logic [2:0]       dump_ph;
    logic [1:0]       grip_ph;
    logic [7:0]       twist_a, shoulder_a, elbow_a, wrist_phys;
    logic [7:0]       saved_tw, saved_sh, saved_el;
    logic [6:0]       grip_a;
    timer_t           t_dstep, t_dpause, t_gstep, t_gclose, t_force;
    int               held_force;

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int gap_of(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic timer_t sat_inc(timer_t t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    function automatic int step_toward(int cur, int tgt);
        return (cur < tgt) ? cur + 1 : ((cur > tgt) ? cur - 1 : cur);
    endfunction

    function automatic logic [7:0] wrist_of(int logical);
        return 8'(clamp_int(logical + int'(WRIST_OFFSET), 0, int'(ANGLE_MAX)));
    endfunction

    function automatic void shadow_reset();
        cfg_m.grip_force_limit     = GRIP_FORCE_LIMIT_RST;
        cfg_m.dump_shoulder_target = DUMP_SHOULDER_TARGET_RST;
        cfg_m.dump_elbow_target    = DUMP_ELBOW_TARGET_RST;
        cfg_m.dump_wrist_tilt      = DUMP_WRIST_TILT_RST;
        cfg_m.step_interval_ms     = STEP_INTERVAL_MS_RST;
        cfg_m.dump_pause_ms        = DUMP_PAUSE_MS_RST;
        cfg_m.close_timeout_ms     = CLOSE_TIMEOUT_MS_RST;
        dump_ph    = TIP_IDLE;
        grip_ph    = JAW_IDLE;
        twist_a    = TWIST_HOME;
        shoulder_a = SHOULDER_HOME;
        elbow_a    = ELBOW_HOME;
        wrist_phys = WRIST_HOME_PHYS;
        grip_a     = GRIP_MIN;
        saved_tw   = '0;
        saved_sh   = '0;
        saved_el   = '0;
        t_dstep    = '0;
        t_dpause   = '0;
        t_gstep    = '0;
        t_gclose   = '0;
        t_force    = '0;
        held_force = 0;
    endfunction

    function automatic void shadow_config(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GRIP_FORCE_LIMIT:     cfg_m.grip_force_limit     = data;
            REG_DUMP_SHOULDER_TARGET: cfg_m.dump_shoulder_target = data[7:0];
            REG_DUMP_ELBOW_TARGET:    cfg_m.dump_elbow_target    = data[7:0];
            REG_DUMP_WRIST_TILT:      cfg_m.dump_wrist_tilt      = data[7:0];
            REG_STEP_INTERVAL_MS:     cfg_m.step_interval_ms     = data[9:0];
            REG_DUMP_PAUSE_MS:        cfg_m.dump_pause_ms        = data[12:0];
            REG_CLOSE_TIMEOUT_MS:     cfg_m.close_timeout_ms     = data[12:0];
            default: ;
        endcase
    endfunction

    // One millisecond of work: wrist leveling, dump sequence, force sampling, gripper.
    function automatic void run_millisecond(logic [23:0] raw);
        int   level;
        int   ts;
        int   te;
        logic stepping;
        level = clamp_int(int'(shoulder_a) + int'(elbow_a) + int'(ELBOW_OFFSET)
                          - int'(SHOULDER_HOME) - int'(ELBOW_HOME), 0, int'(ANGLE_MAX));
        t_dstep  = sat_inc(t_dstep);
        t_dpause = sat_inc(t_dpause);
        t_gstep  = sat_inc(t_gstep);
        t_force  = sat_inc(t_force);

        if (dump_ph == TIP_IDLE) begin
            wrist_phys = wrist_of(level);
        end

        stepping = (t_dstep > cfg_m.step_interval_ms);
        case (dump_ph)
            TIP_TWIST_OUT: begin
                if (stepping) begin
                    if (twist_a != TWIST_HOME)
                        twist_a = 8'(step_toward(int'(twist_a), int'(TWIST_HOME)));
                    else
                        dump_ph = TIP_ARM_OUT;
                    t_dstep = '0;
                end
            end
            TIP_ARM_OUT, TIP_ARM_BACK: begin
                if (stepping) begin
                    ts = (dump_ph == TIP_ARM_OUT) ? int'(cfg_m.dump_shoulder_target)
                                                  : int'(saved_sh);
                    te = (dump_ph == TIP_ARM_OUT) ? int'(cfg_m.dump_elbow_target)
                                                  : int'(saved_el);
                    if (int'(shoulder_a) == ts && int'(elbow_a) == te) begin
                        if (dump_ph == TIP_ARM_OUT) begin
                            dump_ph  = TIP_WAIT_PRE;
                            t_dpause = '0;
                        end else begin
                            dump_ph = TIP_TWIST_BACK;
                        end
                    end
                    shoulder_a = 8'(step_toward(int'(shoulder_a), ts));
                    elbow_a    = 8'(step_toward(int'(elbow_a), te));
                    t_dstep    = '0;
                end
            end
            TIP_WAIT_PRE: begin
                if (t_dpause > cfg_m.dump_pause_ms) dump_ph = TIP_TILT;
            end
            TIP_TILT: begin
                wrist_phys = wrist_of(int'(cfg_m.dump_wrist_tilt));
                t_dpause   = '0;
                dump_ph    = TIP_WAIT_POST;
            end
            TIP_WAIT_POST: begin
                if (t_dpause > cfg_m.dump_pause_ms) begin
                    wrist_phys = wrist_of(level);
                    dump_ph    = TIP_ARM_BACK;
                end
            end
            TIP_TWIST_BACK: begin
                if (stepping) begin
                    if (twist_a != saved_tw)
                        twist_a = 8'(step_toward(int'(twist_a), int'(saved_tw)));
                    else
                        dump_ph = TIP_IDLE;
                    t_dstep = '0;
                end
            end
            default: ;
        endcase

        // The load cell is sampled once every 51 ticks.
        if (t_force > FORCE_READ_MS) begin
            held_force = int'($signed(raw));
            t_force    = '0;
        end

        if (grip_ph == JAW_CLOSING) begin
            if (held_force > int'(cfg_m.grip_force_limit)) begin
                grip_ph = JAW_HOLDING;
            end else if (t_gclose > cfg_m.close_timeout_ms) begin
                grip_ph = JAW_OPENING;
            end else begin
                if (t_gstep > GRIP_CLOSE_MS) begin
                    grip_a  = 7'(clamp_int(int'(grip_a) + 1, int'(GRIP_MIN), int'(GRIP_MAX)));
                    t_gstep = '0;
                end
                t_gclose = sat_inc(t_gclose);
            end
        end else if (grip_ph == JAW_OPENING) begin
            if (t_gstep > GRIP_OPEN_MS) begin
                grip_a  = 7'(clamp_int(int'(grip_a) - 2, int'(GRIP_MIN), int'(GRIP_MAX)));
                t_gstep = '0;
            end
            if (grip_a <= GRIP_MIN) grip_ph = JAW_IDLE;
        end
    endfunction

    // Applies one item to the shadow and returns the servo commands it yields.
    function automatic out_item_t advance_sequencer(in_item_t it);
        out_item_t res;
        case (it.mode)
            MODE_TICK: run_millisecond(it.force_sample);
            MODE_TOGGLE: begin
                if (grip_ph == JAW_IDLE) begin
                    grip_ph  = JAW_CLOSING;
                    t_gclose = '0;
                end else begin
                    grip_ph = JAW_OPENING;
                end
            end
            MODE_OPEN: grip_ph = JAW_OPENING;
            MODE_DUMP: begin
                if (grip_ph == JAW_HOLDING && dump_ph == TIP_IDLE) begin
                    saved_tw = twist_a;
                    saved_sh = shoulder_a;
                    saved_el = elbow_a;
                    dump_ph  = TIP_TWIST_OUT;
                end
            end
            MODE_SET: begin
                case (it.joint_select)
                    SEL_TWIST:
                        twist_a = 8'(clamp_int(int'(it.joint_angle), 0, int'(ANGLE_MAX)));
                    SEL_SHOULDER:
                        shoulder_a = 8'(clamp_int(int'(it.joint_angle), int'(SHOULDER_MIN),
                                                  int'(ANGLE_MAX)));
                    SEL_ELBOW:
                        elbow_a = 8'(clamp_int(int'(it.joint_angle), 0, int'(ANGLE_MAX)));
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.twist_cmd     = 8'(clamp_int(int'(twist_a), 0, int'(ANGLE_MAX)));
        res.shoulder_cmd  = 8'(clamp_int(int'(shoulder_a), int'(SHOULDER_MIN), int'(ANGLE_MAX)));
        res.elbow_cmd     = 8'(clamp_int(int'(elbow_a) + int'(ELBOW_OFFSET), 0,
                                         int'(ANGLE_MAX)));
        res.wrist_cmd     = wrist_phys;
        res.gripper_cmd   = grip_a;
        res.dump_phase    = dump_ph;
        res.gripper_phase = grip_ph;
        return res;
    endfunction

    task automatic report_field(string field, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, exp_v, act_v);
        end
    endtask

    // Input driver: sends queued items with a random wait between transfers.
    always @(posedge aclk) begin : item_driver
        logic taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) servo_cmds_due.push_back(advance_sequencer(s_data));
            if (!s_valid || taken) begin
                if (in_wait != 0) begin
                    in_wait <= in_wait - 1;
                    s_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    s_data  <= items_to_send.pop_front();
                    s_valid <= 1'b1;
                    in_wait <= idle_in ? int'($urandom_range(0, 3)) : 0;
                    if ($urandom_range(0, 63) == 0) idle_in <= !idle_in;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every result transfer and stalls at random.
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        int        stall;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            out_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (servo_cmds_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
            end else begin
                want = servo_cmds_due.pop_front();
                report_field("twist_cmd", want.twist_cmd, m_data.twist_cmd);
                report_field("shoulder_cmd", want.shoulder_cmd, m_data.shoulder_cmd);
                report_field("elbow_cmd", want.elbow_cmd, m_data.elbow_cmd);
                report_field("wrist_cmd", want.wrist_cmd, m_data.wrist_cmd);
                report_field("gripper_cmd", want.gripper_cmd, m_data.gripper_cmd);
                report_field("dump_phase", want.dump_phase, m_data.dump_phase);
                report_field("gripper_phase", want.gripper_phase, m_data.gripper_phase);
            end
            stall = idle_out ? int'($urandom_range(0, 3)) : 0;
            if (stall != 0) begin
                m_ready  <= 1'b0;
                out_wait <= stall - 1;
            end
            if ($urandom_range(0, 63) == 0) idle_out <= !idle_out;
        end else if (!m_ready) begin
            if (out_wait != 0)
                out_wait <= out_wait - 1;
            else
                m_ready <= 1'b1;
        end
    end

    // Shadow copy of the configuration follows every register transfer.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) shadow_config(cfg_index, cfg_data);
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("tb_arm_dump_and_gripper_sequencer_core NOT OK");
            $finish;
        end
    end

    task automatic queue_item(logic [2:0] mode, logic [23:0] force_v, logic [1:0] sel,
                              int angle);
        in_item_t it;
        it.mode         = mode;
        it.force_sample = force_v;
        it.joint_select = sel;
        it.joint_angle  = 8'(angle);
        items_to_send.push_back(it);
        phase_items++;
    endtask

    function automatic logic [23:0] rand_force();
        case ($urandom_range(0, 7))
            0:       return FORCE_POS_MAX;
            1:       return FORCE_NEG_MAX;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] force_above(int lim);
        if (lim >= FORCE_TOP) return FORCE_POS_MAX;
        return 24'($urandom_range(lim + 1, FORCE_TOP));
    endfunction

    function automatic logic [23:0] force_below(int lim);
        if ($urandom_range(0, 1) == 0) return 24'(-int'($urandom_range(1, FORCE_TOP + 1)));
        return 24'($urandom_range(0, lim));
    endfunction

    // A tick with random content in the fields that a tick does not use.
    task automatic queue_tick(logic [23:0] force_v);
        queue_item(MODE_TICK, force_v, 2'($urandom), $urandom_range(0, 255));
    endtask

    task automatic queue_noise();
        logic [2:0] mode;
        mode = ($urandom_range(0, 1) == 0) ? MODE_TICK : 3'($urandom);
        queue_item(mode, rand_force(), 2'($urandom), $urandom_range(0, 255));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_GRIP_FORCE_LIMIT, 23'(c.grip_force_limit));
        write_reg(REG_DUMP_SHOULDER_TARGET, 23'(c.dump_shoulder_target));
        write_reg(REG_DUMP_ELBOW_TARGET, 23'(c.dump_elbow_target));
        write_reg(REG_DUMP_WRIST_TILT, 23'(c.dump_wrist_tilt));
        write_reg(REG_STEP_INTERVAL_MS, 23'(c.step_interval_ms));
        write_reg(REG_DUMP_PAUSE_MS, 23'(c.dump_pause_ms));
        write_reg(REG_CLOSE_TIMEOUT_MS, 23'(c.close_timeout_ms));
    endtask

    // Returns once every queued item has been sent and every result has arrived.
    task automatic wait_idle();
        do @(posedge aclk);
        while (items_to_send.size() != 0 || s_valid || servo_cmds_due.size() != 0);
    endtask

    // Full dump cycle: place the twist near home and the other joints near the
    // targets, grip against the force limit, dump, then release the gripper.
    task automatic queue_dump_cycle(cfg_t c);
        int tw;
        int sh;
        int el;
        int lim;
        int span;
        int n;
        bit low_force;
        tw = int'(TWIST_HOME) + int'($urandom_range(0, 10)) - 5;
        sh = clamp_int(int'(c.dump_shoulder_target) + int'($urandom_range(0, 10)) - 5,
                       int'(SHOULDER_MIN), int'(ANGLE_MAX));
        el = clamp_int(int'(c.dump_elbow_target) + int'($urandom_range(0, 10)) - 5,
                       0, int'(ANGLE_MAX));
        queue_item(MODE_SET, rand_force(), SEL_TWIST, tw);
        queue_item(MODE_SET, rand_force(), SEL_SHOULDER, sh);
        queue_item(MODE_SET, rand_force(), SEL_ELBOW, el);
        queue_item(MODE_TOGGLE, rand_force(), 2'($urandom), $urandom_range(0, 255));

        // A weak grip lets the close timeout fire instead.
        lim       = int'(c.grip_force_limit);
        low_force = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(52, 60))
            queue_tick(low_force ? force_below(lim) : force_above(lim));
        queue_item(MODE_DUMP, rand_force(), 2'($urandom), $urandom_range(0, 255));

        span = 2 * (gap_of(tw, int'(TWIST_HOME)) + 1)
             + 2 * (((gap_of(sh, int'(c.dump_shoulder_target))
                      > gap_of(el, int'(c.dump_elbow_target)))
                     ? gap_of(sh, int'(c.dump_shoulder_target))
                     : gap_of(el, int'(c.dump_elbow_target))) + 1);
        n = span * (int'(c.step_interval_ms) + 1) + 2 * (int'(c.dump_pause_ms) + 2)
            + 4 + int'($urandom_range(0, 8));
        if (n > DUMP_TICK_CAP) n = DUMP_TICK_CAP;
        repeat (n) begin
            if ($urandom_range(0, 39) == 0)
                queue_noise();
            else
                queue_tick(rand_force());
        end
        queue_item(MODE_OPEN, rand_force(), 2'($urandom), $urandom_range(0, 255));
        repeat ($urandom_range(22, 30)) queue_tick(rand_force());
    endtask

    task automatic run_phase(cfg_t c, int budget);
        load_config(c);
        phase_items = 0;
        while (phase_items < budget) begin
            if ($urandom_range(0, 9) < 7)
                queue_dump_cycle(c);
            else
                repeat ($urandom_range(10, 30)) queue_noise();
        end
        wait_idle();
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.grip_force_limit     = ($urandom_range(0, 3) == 0) ? 23'($urandom)
                                                             : 23'($urandom_range(0, 4000));
        c.dump_shoulder_target = 8'($urandom_range(60, 180));
        c.dump_elbow_target    = 8'($urandom_range(0, 180));
        c.dump_wrist_tilt      = 8'($urandom_range(0, 180));
        c.step_interval_ms     = 10'($urandom_range(0, 2));
        c.dump_pause_ms        = 13'($urandom_range(0, 15));
        c.close_timeout_ms     = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 30))
                                                             : 13'($urandom_range(60, 400));
        return c;
    endfunction

    initial begin
        cfg_t c;
        shadow_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset configuration.
        queue_tick(FORCE_POS_MAX);
        queue_tick(FORCE_NEG_MAX);
        queue_tick(24'd0);
        queue_item(MODE_SET, 24'd0, SEL_TWIST, 0);
        queue_item(MODE_SET, 24'd0, SEL_TWIST, 255);
        queue_item(MODE_SET, 24'd0, SEL_SHOULDER, 0);
        queue_item(MODE_SET, 24'd0, SEL_SHOULDER, 255);
        queue_item(MODE_SET, 24'd0, SEL_ELBOW, 0);
        queue_item(MODE_SET, 24'd0, SEL_ELBOW, 255);
        queue_item(MODE_SET, 24'd0, SEL_NONE, 77);
        queue_item(MODE_DUMP, 24'd0, SEL_TWIST, 0);
        queue_item(MODE_TOGGLE, 24'd0, SEL_TWIST, 0);
        queue_tick(FORCE_POS_MAX);
        queue_item(MODE_TOGGLE, 24'd0, SEL_TWIST, 0);
        queue_item(MODE_OPEN, 24'd0, SEL_TWIST, 0);
        queue_item(MODE_TOGGLE, 24'd0, SEL_TWIST, 0);
        queue_item(MODE_SPARE_LO, FORCE_POS_MAX, SEL_NONE, 255);
        queue_item(MODE_SPARE_HI, FORCE_NEG_MAX, SEL_NONE, 255);
        queue_item(MODE_SET, 24'd0, SEL_TWIST, int'(TWIST_HOME));
        queue_item(MODE_SET, 24'd0, SEL_SHOULDER, int'(SHOULDER_HOME));
        queue_item(MODE_SET, 24'd0, SEL_ELBOW, int'(ELBOW_HOME));
        wait_idle();

        // Upper extremes of every register but the step interval, which is set to 1000.
        c.grip_force_limit     = LIMIT_TOP;
        c.dump_shoulder_target = ANGLE_MAX;
        c.dump_elbow_target    = ANGLE_MAX;
        c.dump_wrist_tilt      = ANGLE_MAX;
        c.step_interval_ms     = 10'd1000;
        c.dump_pause_ms        = '1;
        c.close_timeout_ms     = '1;
        run_phase(c, 150);

        repeat (3) run_phase(random_cfg(), 350);

        // Lower extremes of every register.
        c.grip_force_limit     = '0;
        c.dump_shoulder_target = SHOULDER_MIN;
        c.dump_elbow_target    = '0;
        c.dump_wrist_tilt      = '0;
        c.step_interval_ms     = '0;
        c.dump_pause_ms        = '0;
        c.close_timeout_ms     = '0;
        run_phase(c, 250);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && servo_cmds_due.size() == 0)
            $display("tb_arm_dump_and_gripper_sequencer_core OK");
        else
            $display("tb_arm_dump_and_gripper_sequencer_core NOT OK");
        $finish;
    end

endmodule
